/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 3;
	localparam int STS_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} sts_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} back_state_t;

	// decoded request passed from the front part to the back part
	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
	} deq_cmd_t;

endpackage

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values held in a ring store
// ----------------------------------------------------------------------------
// each request carries a command in s_axis_tuser and a value in s_axis_tdata.
// a front part drops unknown commands and parks the rest in a two-entry
// queue; a back part owns the ring store, the front index and the item
// count and writes results into an output register; while a result waits
// on the master side, the front queue still takes requests until it is full.
// a push is done in the idle state of the back part; a pop or a dump of a
// non-empty queue goes through a read state, the store having a registered
// read port, and a dump walks the store one entry per cycle through that port
// unless the result side stalls. every push and pop gives one result with
// tlast set; a dump of an empty queue gives one empty result. results with
// status empty or full carry zero data. the store is not cleared at reset;
// only occupied slots are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	// request side
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic signed [deq_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] value
	input  logic [deq_pkg::CMD_W-1:0]          s_axis_tuser,  // [2:0] command
	// result side
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic signed [deq_pkg::DATA_W-1:0]  m_axis_tdata,  // [31:0] result_value
	output logic [deq_pkg::STS_W-1:0]          m_axis_tuser,  // [1:0] status
	output logic                               m_axis_tlast   // last result of a request
);

	// decoded request between front and back
	logic              cmd_valid;
	logic              cmd_ready;
	deq_pkg::deq_cmd_t cmd;

	// front: classify and buffer
	deq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: ring store and result register
	deq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (m_axis_tdata),
		.out_status (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

/* rtl/deq_front.sv */
// ----------------------------------------------------------------------------
// deq_front
// accepts requests, drops unknown commands, buffers the rest in a short queue
// ----------------------------------------------------------------------------
module deq_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [deq_pkg::CMD_W-1:0]         in_cmd,
	input  logic signed [deq_pkg::DATA_W-1:0] in_value,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output deq_pkg::deq_cmd_t                 cmd
);

	deq_pkg::deq_cmd_t fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	logic              keep;
	logic              push;
	logic              pop;

	// classify: only the five known commands go on
	always_comb begin
		unique case (in_cmd)
			deq_pkg::CMD_PUSH_FRONT,
			deq_pkg::CMD_PUSH_BACK,
			deq_pkg::CMD_POP_FRONT,
			deq_pkg::CMD_POP_BACK,
			deq_pkg::CMD_DUMP: keep = 1'b1;
			default:           keep = 1'b0;
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].cmd   <= deq_pkg::cmd_t'(in_cmd);
			fifo_q[wr_ptr_q].value <= in_value;
		end
	end

endmodule

/* rtl/deq_back.sv */
// ----------------------------------------------------------------------------
// deq_back
// ring store with front index and count, executes requests, drives results
// ----------------------------------------------------------------------------
module deq_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  deq_pkg::deq_cmd_t                  cmd,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [deq_pkg::DATA_W-1:0]  out_value,
	output logic [deq_pkg::STS_W-1:0]          out_status,
	output logic                               out_last
);

	localparam int IW = deq_pkg::IDX_W;
	localparam int CW = deq_pkg::CNT_W;

	deq_pkg::back_state_t state_q, state_d;

	logic signed [deq_pkg::DATA_W-1:0] entries_q [deq_pkg::CAPACITY];
	logic signed [deq_pkg::DATA_W-1:0] rdata_q;
	logic [IW-1:0]  front_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  rem_q;
	logic [IW-1:0]  rd_ptr_q;

	logic                              out_valid_q;
	logic signed [deq_pkg::DATA_W-1:0] out_value_q;
	logic [deq_pkg::STS_W-1:0]         out_status_q;
	logic                              out_last_q;

	logic           slot_free;
	logic           take;
	logic           is_full;
	logic           is_empty;
	logic [CW:0]    sum_back;
	logic [CW:0]    sum_tail;
	logic [IW-1:0]  back_slot;
	logic [IW-1:0]  tail_slot;
	logic [IW-1:0]  front_dec;
	logic [IW-1:0]  front_inc;
	logic [IW-1:0]  rd_ptr_inc;

	// datapath controls
	logic                              wr_en;
	logic [IW-1:0]                     wr_addr;
	logic                              rd_en;
	logic [IW-1:0]                     rd_addr;
	logic                              load;
	logic signed [deq_pkg::DATA_W-1:0] load_value;
	logic [deq_pkg::STS_W-1:0]         load_status;
	logic                              load_last;
	logic                              front_we;
	logic [IW-1:0]                     front_d;
	logic                              count_we;
	logic [CW-1:0]                     count_d;
	logic                              rem_we;
	logic [CW-1:0]                     rem_d;

	assign slot_free = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == deq_pkg::ST_IDLE) && slot_free;
	assign take      = cmd_valid && cmd_ready;
	assign is_full   = (count_q == CW'(deq_pkg::CAPACITY));
	assign is_empty  = (count_q == '0);

	// ring arithmetic, sums stay below twice the capacity where they are used
	assign sum_back  = {1'b0, CW'(front_q)} + {1'b0, count_q} - (CW+1)'(1);
	assign back_slot = (sum_back >= (CW+1)'(deq_pkg::CAPACITY))
		? IW'(sum_back - (CW+1)'(deq_pkg::CAPACITY)) : IW'(sum_back);
	assign sum_tail  = {1'b0, CW'(front_q)} + {1'b0, count_q};
	assign tail_slot = (sum_tail >= (CW+1)'(deq_pkg::CAPACITY))
		? IW'(sum_tail - (CW+1)'(deq_pkg::CAPACITY)) : IW'(sum_tail);
	assign front_dec = (front_q == '0) ? IW'(deq_pkg::CAPACITY - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(deq_pkg::CAPACITY - 1)) ? '0 : front_q + IW'(1);
	assign rd_ptr_inc = (rd_ptr_q == IW'(deq_pkg::CAPACITY - 1)) ? '0 : rd_ptr_q + IW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				if (take && !is_empty && (cmd.cmd == deq_pkg::CMD_POP_FRONT ||
					cmd.cmd == deq_pkg::CMD_POP_BACK || cmd.cmd == deq_pkg::CMD_DUMP))
					state_d = deq_pkg::ST_READ;
			end
			deq_pkg::ST_READ: begin
				if (slot_free && rem_q == '0) state_d = deq_pkg::ST_IDLE;
			end
			default: state_d = deq_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = front_dec;
		rd_en       = 1'b0;
		rd_addr     = front_q;
		load        = 1'b0;
		load_value  = '0;
		load_status = deq_pkg::STS_OK;
		load_last   = 1'b1;
		front_we    = 1'b0;
		front_d     = front_q;
		count_we    = 1'b0;
		count_d     = count_q;
		rem_we      = 1'b0;
		rem_d       = '0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				if (take) begin
					case (cmd.cmd)
						deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
							load = 1'b1;
							if (is_full) begin
								load_status = deq_pkg::STS_FULL;
							end else begin
								wr_en    = 1'b1;
								count_we = 1'b1;
								count_d  = count_q + CW'(1);
								if (cmd.cmd == deq_pkg::CMD_PUSH_FRONT) begin
									wr_addr  = front_dec;
									front_we = 1'b1;
									front_d  = front_dec;
								end else begin
									wr_addr = tail_slot;
								end
							end
						end
						default: begin
							if (is_empty) begin
								load        = 1'b1;
								load_status = deq_pkg::STS_EMPTY;
							end else begin
								rd_en  = 1'b1;
								rem_we = 1'b1;
								if (cmd.cmd == deq_pkg::CMD_POP_FRONT) begin
									rd_addr  = front_q;
									front_we = 1'b1;
									front_d  = front_inc;
									count_we = 1'b1;
									count_d  = count_q - CW'(1);
								end else if (cmd.cmd == deq_pkg::CMD_POP_BACK) begin
									rd_addr  = back_slot;
									count_we = 1'b1;
									count_d  = count_q - CW'(1);
								end else begin
									rd_addr = front_q;
									rem_d   = count_q - CW'(1);
								end
							end
						end
					endcase
				end
			end
			deq_pkg::ST_READ: begin
				if (slot_free) begin
					load       = 1'b1;
					load_value = rdata_q;
					load_last  = (rem_q == '0);
					if (rem_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = rd_ptr_inc;
						rem_we  = 1'b1;
						rem_d   = rem_q - CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (front_we) front_q <= front_d;
			if (count_we) count_q <= count_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// store, read port and payload registers
	always_ff @(posedge clk) begin
		if (wr_en) entries_q[wr_addr] <= cmd.value;
		if (rd_en) begin
			rdata_q  <= entries_q[rd_addr];
			rd_ptr_q <= rd_addr;
		end
		if (rem_we) rem_q <= rem_d;
		if (load) begin
			out_value_q  <= load_value;
			out_status_q <= load_status;
			out_last_q   <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

/* rtl/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks on the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module deq_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic signed [deq_pkg::DATA_W-1:0]  m_axis_tdata,
	input  logic [deq_pkg::STS_W-1:0]          m_axis_tuser,
	input  logic                               m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// empty or full results are single, last, and carry zero data
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != deq_pkg::STS_OK |->
			m_axis_tlast && m_axis_tdata == '0)
		else $error("error result malformed");

	// no result on the cycle after reset is seen
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result during reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the double-ended queue
// ----------------------------------------------------------------------------
// requests come from a queue that the stimulus block fills: a short directed
// list (empty pops and dump, ignored commands, extreme values, front pop
// followed by back pop, front push wrapping the ring), then random traffic
// that swings the queue from empty to full and back. every accepted request
// goes through a local copy of the ring store, which posts the results it
// should cause; the result side checks value, status and last flag against
// them in order. both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	// one pending request
	typedef struct {
		logic [deq_pkg::CMD_W-1:0]  code;
		logic [deq_pkg::DATA_W-1:0] word;
	} request_t;

	// one result the ring store should produce
	typedef struct {
		logic [deq_pkg::DATA_W-1:0] word;
		deq_pkg::sts_t              status;
		logic                       tail;
	} outcome_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic signed [deq_pkg::DATA_W-1:0] s_axis_tdata = '0;
	logic [deq_pkg::CMD_W-1:0]         s_axis_tuser = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic signed [deq_pkg::DATA_W-1:0] m_axis_tdata;
	logic [deq_pkg::STS_W-1:0]         m_axis_tuser;
	logic                              m_axis_tlast;

	request_t request_queue[$];
	outcome_t due_results[$];

	// local copy of the ring store
	logic [deq_pkg::DATA_W-1:0] ring [deq_pkg::CAPACITY];
	int                         head = 0;
	int                         fill = 0;

	// bookkeeping
	int errors = 0;
	int n_push = 0;
	int n_pop = 0;
	int n_dump = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_empty = 0;
	int peak = 0;

	// stimulus-side occupancy, used only to steer the random mix
	int  gen_fill = 0;
	bit  gen_hit_full = 0;

	// idle state of each side
	int       send_gap = 0;
	int       send_calm = 0;
	int       take_stall = 0;
	int       take_calm = 0;
	request_t next_req;

	double_ended_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int pick_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// queue a request and follow the occupancy it leads to
	function automatic void add_req(logic [deq_pkg::CMD_W-1:0] code,
		logic [deq_pkg::DATA_W-1:0] word);
		request_t r;
		r.code = code;
		r.word = word;
		request_queue.push_back(r);
		if (code == deq_pkg::CMD_PUSH_FRONT || code == deq_pkg::CMD_PUSH_BACK) begin
			if (gen_fill == deq_pkg::CAPACITY)
				gen_hit_full = 1'b1;
			else
				gen_fill++;
		end else if ((code == deq_pkg::CMD_POP_FRONT || code == deq_pkg::CMD_POP_BACK)
			&& gen_fill > 0) begin
			gen_fill--;
		end
	endfunction

	function automatic void post_result(logic [deq_pkg::DATA_W-1:0] word,
		deq_pkg::sts_t status, logic tail);
		outcome_t o;
		o.word = word;
		o.status = status;
		o.tail = tail;
		due_results.push_back(o);
	endfunction

	// ring store behavior for one accepted request
	function automatic void apply_request(logic [deq_pkg::CMD_W-1:0] code,
		logic [deq_pkg::DATA_W-1:0] word);
		int slot;
		case (code)
			deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
				n_push++;
				if (fill == deq_pkg::CAPACITY) begin
					n_full++;
					post_result('0, deq_pkg::STS_FULL, 1'b1);
				end else begin
					if (code == deq_pkg::CMD_PUSH_FRONT) begin
						head = (head + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
						ring[head] = word;
					end else begin
						ring[(head + fill) % deq_pkg::CAPACITY] = word;
					end
					fill++;
					if (fill > peak)
						peak = fill;
					post_result('0, deq_pkg::STS_OK, 1'b1);
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
				n_pop++;
				if (fill == 0) begin
					n_empty++;
					post_result('0, deq_pkg::STS_EMPTY, 1'b1);
				end else if (code == deq_pkg::CMD_POP_FRONT) begin
					post_result(ring[head], deq_pkg::STS_OK, 1'b1);
					head = (head + 1) % deq_pkg::CAPACITY;
					fill--;
				end else begin
					slot = (head + fill - 1) % deq_pkg::CAPACITY;
					post_result(ring[slot], deq_pkg::STS_OK, 1'b1);
					fill--;
				end
			end
			deq_pkg::CMD_DUMP: begin
				n_dump++;
				if (fill == 0) begin
					n_empty++;
					post_result('0, deq_pkg::STS_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < fill; i++)
						post_result(ring[(head + i) % deq_pkg::CAPACITY], deq_pkg::STS_OK,
							i == fill - 1);
				end
			end
			default: begin
				// unknown commands are dropped without a result
				n_ignored++;
			end
		endcase
	endfunction

	// compare one accepted result with the oldest expectation
	function automatic void check_result(logic [deq_pkg::DATA_W-1:0] word,
		logic [deq_pkg::STS_W-1:0] status, logic tail);
		outcome_t o;
		if (due_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result value %h status %0d last %b",
				$time, word, status, tail);
			return;
		end
		o = due_results.pop_front();
		n_checked++;
		if (word !== o.word) begin
			errors++;
			$display("%0t: result value expected %h actual %h", $time, o.word, word);
		end
		if (status !== o.status) begin
			errors++;
			$display("%0t: status expected %0d actual %0d", $time, o.status, status);
		end
		if (tail !== o.tail) begin
			errors++;
			$display("%0t: last expected %b actual %b", $time, o.tail, tail);
		end
	endfunction

	// request driver: holds a request until it is taken, then idles or sends the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_request(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_req.word;
					s_axis_tuser <= next_req.code;
					send_gap <= pick_gap(send_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each taken result and stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			take_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (take_stall != 0) begin
				take_stall <= take_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				take_stall <= pick_gap(take_calm);
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [deq_pkg::DATA_W-1:0] v;
		int                         counted;
		int                         r;
		bit                         filling;

		// directed: empty queue first
		add_req(deq_pkg::CMD_DUMP, $urandom);
		add_req(deq_pkg::CMD_POP_FRONT, $urandom);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		// unknown commands are dropped
		add_req(3'd5, $urandom);
		add_req(3'd6, $urandom);
		add_req(3'd7, $urandom);
		// extremes at both ends, front push wraps below slot zero
		add_req(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
		add_req(deq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
		add_req(deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
		add_req(deq_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
		add_req(deq_pkg::CMD_DUMP, $urandom);
		// front pop then back pop must leave both ends consistent
		add_req(deq_pkg::CMD_POP_FRONT, $urandom);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		add_req(deq_pkg::CMD_DUMP, $urandom);
		add_req(deq_pkg::CMD_POP_FRONT, $urandom);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		add_req(deq_pkg::CMD_PUSH_BACK, 32'h5555_aaaa);
		add_req(deq_pkg::CMD_PUSH_FRONT, 32'haaaa_5555);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		add_req(deq_pkg::CMD_POP_BACK, $urandom);
		add_req(deq_pkg::CMD_POP_FRONT, $urandom);

		// random: fill toward full, drain toward empty, repeat
		counted = 0;
		filling = 1'b1;
		while (counted < 75 || !gen_hit_full) begin
			if (filling && gen_fill == deq_pkg::CAPACITY && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && gen_fill == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
			r = $urandom_range(0, 9);
			case (r)
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
				default: v = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < 4) begin
				add_req(deq_pkg::CMD_W'($urandom_range(5, 7)), v);
			end else begin
				counted++;
				if (r < 10)
					add_req(deq_pkg::CMD_DUMP, v);
				else if ((r < 80) == filling)
					add_req($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT
						: deq_pkg::CMD_PUSH_BACK, v);
				else
					add_req($urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT
						: deq_pkg::CMD_POP_BACK, v);
			end
		end

		// hold reset, then release it away from the clock edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all requests taken, then all results in, then a quiet tail
		while (request_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("covered %0d pushes, %0d pops, %0d dumps, %0d dropped commands",
			n_push, n_pop, n_dump, n_ignored);
		$display("checked %0d results: %0d full, %0d empty, peak occupancy %0d",
			n_checked, n_full, n_empty, peak);
		if (errors == 0) begin
			$display("double_ended_queue verification clean");
		end else begin
			$display("double_ended_queue verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", due_results.size());
		$display("double_ended_queue verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/deq_pkg.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/testbench.sv
